[src/ustc_pkg.sv]
// ----------------------------------------------------------------------------
// ustc_pkg
// Shared constants and calendar helpers for the seconds-to-calendar pipeline.
// ----------------------------------------------------------------------------
package ustc_pkg;

  localparam int unsigned EPOCH_YEAR    = 1970;
  localparam int unsigned EPOCH_WEEKDAY = 4;     // 1970-01-01 was a Thursday
  localparam int unsigned DAYS_PER_WEEK = 7;
  localparam int unsigned DAYS_COMMON   = 365;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned MONTHS        = 12;

  // Payload widths
  localparam int unsigned SECS_W  = 32;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;

  // Internal widths
  localparam int unsigned DAYS_W  = 16;  // whole days since epoch, max 49710
  localparam int unsigned SOD_W   = 17;  // seconds of day, max 86399
  localparam int unsigned YIDX_W  = 8;   // years since 1970, max 136
  localparam int unsigned DOY_W   = 9;   // day of year, 0..365
  localparam int unsigned RSEC_W  = 12;  // seconds of hour, 0..3599

  // Reciprocal constants (multiply then shift gives an exact floor)
  // days = (t >> 7) / 675      : x < 2^25
  localparam logic [25:0] RCP_DAY      = 26'd50903317;
  localparam int unsigned RCP_DAY_SH   = 35;
  localparam logic [9:0]  DAY_DIV_ODD  = 10'd675;
  // year estimate = days / 365.25 (within one of the true year)
  localparam logic [15:0] RCP_YEAR     = 16'd45934;
  localparam int unsigned RCP_YEAR_SH  = 24;
  // (days + 4) / 7             : x < 2^16
  localparam logic [16:0] RCP_WEEK     = 17'd74899;
  localparam int unsigned RCP_WEEK_SH  = 19;
  // hour = (sod >> 4) / 225    : x < 2^13
  localparam logic [13:0] RCP_HOUR     = 14'd9321;
  localparam int unsigned RCP_HOUR_SH  = 21;
  // minute = (rsec >> 2) / 15  : x < 2^10
  localparam logic [10:0] RCP_MIN      = 11'd1093;
  localparam int unsigned RCP_MIN_SH   = 14;

  // Year index of 2100 and first index after it that misses that leap day
  localparam logic [YIDX_W-1:0] YIDX_2100 = YIDX_W'(2100 - EPOCH_YEAR);
  localparam logic [YIDX_W-1:0] YIDX_2101 = YIDX_W'(2101 - EPOCH_YEAR);

  // Day of year on which each month starts, common year
  localparam logic [DOY_W-1:0] MONTH_START [MONTHS] = '{
    9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // First day (since epoch) of year index y
  function automatic logic [DAYS_W-1:0] year_start(input logic [YIDX_W-1:0] y);
    logic [YIDX_W:0]   yp1;
    logic [DAYS_W-1:0] base;
    yp1  = {1'b0, y} + (YIDX_W+1)'(1);
    base = DAYS_W'(y) * DAYS_W'(DAYS_COMMON) + DAYS_W'(yp1[YIDX_W:2]);
    if (y >= YIDX_2101) begin
      base = base - DAYS_W'(1);
    end
    return base;
  endfunction

  function automatic logic is_leap(input logic [YIDX_W-1:0] y);
    return (y[1:0] == 2'd2) && (y != YIDX_2100);
  endfunction

  function automatic logic [DOY_W-1:0] month_first(input logic [MONTH_W-1:0] idx,
                                                    input logic              leap);
    logic [DOY_W-1:0] d;
    d = MONTH_START[idx];
    if (leap && (idx >= MONTH_W'(2))) begin
      d = d + DOY_W'(1);
    end
    return d;
  endfunction

endpackage

[src/ustc_if.sv]
// ----------------------------------------------------------------------------
// ustc_if
// Valid/ready channels for the seconds-to-calendar block.
// ----------------------------------------------------------------------------
interface ustc_in_if import ustc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SECS_W-1:0] unix_seconds;

  modport source (output valid, output unix_seconds, input ready);
  modport sink   (input valid, input unix_seconds, output ready);
endinterface

interface ustc_out_if import ustc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0]   day_of_month;
  logic [WDAY_W-1:0]  weekday;
  logic [HOUR_W-1:0]  hour;
  logic [MIN_W-1:0]   minute;
  logic [SEC_W-1:0]   second;

  modport source (output valid, output year, output month, output day_of_month,
                  output weekday, output hour, output minute, output second,
                  input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input weekday, input hour, input minute, input second,
                  output ready);
endinterface

[src/unix_seconds_to_calendar.sv]
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar
// Seconds since 1970-01-01 00:00:00 UTC to Gregorian date, weekday and time.
// ----------------------------------------------------------------------------
// Fully pipelined converter: one transaction can enter every clock unless the
// output is stalled. There are seven register stages; the accepting edge loads
// stage 1, and results are delivered on out_ch in input order.
// The seven stages are set by the constant divisions (days, weekday, hour,
// minute), each done as a reciprocal multiply followed by a registered
// back-multiply and subtract, and by the year and month lookups. When the
// result register is full and out_ch.ready is low the whole pipe freezes,
// and in_ch.ready drops in the same cycle; nothing is dropped or repeated.
// Every 32-bit input is legal (up to 2106-02-07 06:28:15); leap years follow
// the Gregorian rule over that range, so 2100 has no Feb 29. The block holds no state
// beyond the pipeline itself.
//
// Stage map:
//   1  t * 1/86400 reciprocal product
//   2  whole days, seconds of day
//   3  year estimate, weekday and hour reciprocal products
//   4  three candidate year starts, weekday, hour, seconds of hour
//   5  year pick, day of year, leap flag, minute reciprocal product
//   6  month by parallel compare, minute, second
//   7  day of month (result register)
module unix_seconds_to_calendar import ustc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  ustc_in_if.sink       in_ch,
  ustc_out_if.source    out_ch
);

  // Global advance: everything moves unless the result register is blocked
  logic adv;
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // Valid bits travel with the data
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;

  // ---- Stage 1 ------------------------------------------------------------
  logic [SECS_W-1:0] t1_r;
  logic [50:0]       pday1_r;

  // ---- Stage 2 ------------------------------------------------------------
  logic [DAYS_W-1:0] days2_nxt, days2_r;
  logic [25:0]       dayback2;
  logic [25:0]       lo2;
  logic [SOD_W-1:0]  sod2_nxt, sod2_r;

  assign days2_nxt = pday1_r[RCP_DAY_SH +: DAYS_W];
  assign dayback2  = 26'(days2_nxt) * 26'(DAY_DIV_ODD);
  assign lo2       = 26'(t1_r[SECS_W-1:7]) - dayback2;
  assign sod2_nxt  = {lo2[9:0], t1_r[6:0]};

  // ---- Stage 3 ------------------------------------------------------------
  logic [DAYS_W-1:0] days3_r;
  logic [DAYS_W-1:0] dw3_r;             // days + epoch weekday offset
  logic [SOD_W-1:0]  sod3_r;
  logic [31:0]       pyr3_r;
  logic [32:0]       pwk3_r;
  logic [26:0]       phr3_r;
  logic [DAYS_W-1:0] dw3_nxt;

  assign dw3_nxt = days2_r + DAYS_W'(EPOCH_WEEKDAY);

  // ---- Stage 4 ------------------------------------------------------------
  logic [YIDX_W-1:0] e4_nxt, e4_r;
  logic [DAYS_W-1:0] stm4_nxt, st0_4_nxt, stp4_nxt;
  logic [DAYS_W-1:0] stm4_r, st0_4_r, stp4_r;
  logic [DAYS_W-1:0] days4_r;
  logic [13:0]       qwk4;
  logic [DAYS_W-1:0] wkfull4;
  logic [WDAY_W-1:0] wk4_r;
  logic [HOUR_W-1:0] hour4_nxt, hour4_r;
  logic [SOD_W-1:0]  rfull4;
  logic [RSEC_W-1:0] rsec4_r;

  assign e4_nxt    = pyr3_r[RCP_YEAR_SH +: YIDX_W];
  // e == 0 never selects the lower candidate (days >= 0 = start of 1970)
  assign stm4_nxt  = (e4_nxt == '0) ? '0 : year_start(e4_nxt - YIDX_W'(1));
  assign st0_4_nxt = year_start(e4_nxt);
  assign stp4_nxt  = year_start(e4_nxt + YIDX_W'(1));
  assign qwk4      = pwk3_r[RCP_WEEK_SH +: 14];
  assign wkfull4   = dw3_r - (DAYS_W'(qwk4) * DAYS_W'(DAYS_PER_WEEK));
  assign hour4_nxt = phr3_r[RCP_HOUR_SH +: HOUR_W];
  assign rfull4    = sod3_r - (SOD_W'(hour4_nxt) * SOD_W'(SECS_PER_HOUR));

  // ---- Stage 5 ------------------------------------------------------------
  logic [YIDX_W-1:0] y5_nxt, y5_r;
  logic [DAYS_W-1:0] ystart5;
  logic [DAYS_W-1:0] doyfull5;
  logic [DOY_W-1:0]  doy5_r;
  logic              leap5_r;
  logic [WDAY_W-1:0] wk5_r;
  logic [HOUR_W-1:0] hour5_r;
  logic [RSEC_W-1:0] rsec5_r;
  logic [20:0]       pmin5_r;

  // Estimate is within one year of the truth; bracket it
  always_comb begin
    if (days4_r < st0_4_r) begin
      y5_nxt  = e4_r - YIDX_W'(1);
      ystart5 = stm4_r;
    end else if (days4_r >= stp4_r) begin
      y5_nxt  = e4_r + YIDX_W'(1);
      ystart5 = stp4_r;
    end else begin
      y5_nxt  = e4_r;
      ystart5 = st0_4_r;
    end
  end
  assign doyfull5 = days4_r - ystart5;

  // ---- Stage 6 ------------------------------------------------------------
  logic [MONTH_W-1:0] mon6_nxt, mon6_r;
  logic [DOY_W-1:0]   doy6_r;
  logic               leap6_r;
  logic [YIDX_W-1:0]  y6_r;
  logic [WDAY_W-1:0]  wk6_r;
  logic [HOUR_W-1:0]  hour6_r;
  logic [MIN_W-1:0]   min6_nxt, min6_r;
  logic [RSEC_W-1:0]  sfull6;
  logic [SEC_W-1:0]   sec6_r;

  // Month = 1 + number of later month starts already reached
  always_comb begin
    mon6_nxt = MONTH_W'(1);
    for (int i = 1; i < MONTHS; i++) begin
      if (doy5_r >= month_first(MONTH_W'(i), leap5_r)) begin
        mon6_nxt = mon6_nxt + MONTH_W'(1);
      end
    end
  end
  assign min6_nxt = pmin5_r[RCP_MIN_SH +: MIN_W];
  assign sfull6   = rsec5_r - (RSEC_W'(min6_nxt) * RSEC_W'(SECS_PER_MIN));

  // ---- Stage 7 ------------------------------------------------------------
  logic [DOY_W-1:0]   dfull7;
  logic [YEAR_W-1:0]  year7_r;
  logic [MONTH_W-1:0] mon7_r;
  logic [DAY_W-1:0]   day7_r;
  logic [WDAY_W-1:0]  wk7_r;
  logic [HOUR_W-1:0]  hour7_r;
  logic [MIN_W-1:0]   min7_r;
  logic [SEC_W-1:0]   sec7_r;

  assign dfull7 = doy6_r - month_first(mon6_r - MONTH_W'(1), leap6_r) + DOY_W'(1);

  // ---- Valid chain ----------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  // ---- Datapath registers (no reset) ----------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      t1_r    <= in_ch.unix_seconds;
      pday1_r <= 51'(in_ch.unix_seconds[SECS_W-1:7]) * 51'(RCP_DAY);
      // stage 2
      days2_r <= days2_nxt;
      sod2_r  <= sod2_nxt;
      // stage 3
      days3_r <= days2_r;
      dw3_r   <= dw3_nxt;
      sod3_r  <= sod2_r;
      pyr3_r  <= 32'(days2_r) * 32'(RCP_YEAR);
      pwk3_r  <= 33'(dw3_nxt) * 33'(RCP_WEEK);
      phr3_r  <= 27'(sod2_r[SOD_W-1:4]) * 27'(RCP_HOUR);
      // stage 4
      e4_r    <= e4_nxt;
      stm4_r  <= stm4_nxt;
      st0_4_r <= st0_4_nxt;
      stp4_r  <= stp4_nxt;
      days4_r <= days3_r;
      wk4_r   <= wkfull4[WDAY_W-1:0];
      hour4_r <= hour4_nxt;
      rsec4_r <= rfull4[RSEC_W-1:0];
      // stage 5
      y5_r    <= y5_nxt;
      doy5_r  <= doyfull5[DOY_W-1:0];
      leap5_r <= is_leap(y5_nxt);
      wk5_r   <= wk4_r;
      hour5_r <= hour4_r;
      rsec5_r <= rsec4_r;
      pmin5_r <= 21'(rsec4_r[RSEC_W-1:2]) * 21'(RCP_MIN);
      // stage 6
      mon6_r  <= mon6_nxt;
      doy6_r  <= doy5_r;
      leap6_r <= leap5_r;
      y6_r    <= y5_r;
      wk6_r   <= wk5_r;
      hour6_r <= hour5_r;
      min6_r  <= min6_nxt;
      sec6_r  <= sfull6[SEC_W-1:0];
      // stage 7
      year7_r <= YEAR_W'(EPOCH_YEAR) + YEAR_W'(y6_r);
      mon7_r  <= mon6_r;
      day7_r  <= dfull7[DAY_W-1:0];
      wk7_r   <= wk6_r;
      hour7_r <= hour6_r;
      min7_r  <= min6_r;
      sec7_r  <= sec6_r;
    end
  end

  assign out_ch.valid        = v7_r;
  assign out_ch.year         = year7_r;
  assign out_ch.month        = mon7_r;
  assign out_ch.day_of_month = day7_r;
  assign out_ch.weekday      = wk7_r;
  assign out_ch.hour         = hour7_r;
  assign out_ch.minute       = min7_r;
  assign out_ch.second       = sec7_r;

  // ---- Assertions -----------------------------------------------------------
  // Year pick must leave a day of year inside that year
  a_doy_in_year: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> (doy5_r < (DOY_W'(DAYS_COMMON) + DOY_W'(leap5_r))))
    else $error("day of year outside selected year");

  // Hour reciprocal must leave less than one hour behind
  a_rsec_range: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (rsec4_r < RSEC_W'(SECS_PER_HOUR)))
    else $error("seconds of hour out of range");

  // Delivered fields stay in their calendar ranges
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.month >= MONTH_W'(1)) && (out_ch.month <= MONTH_W'(MONTHS))
      && (out_ch.day_of_month >= DAY_W'(1)) && (out_ch.weekday < WDAY_W'(DAYS_PER_WEEK))
      && (out_ch.hour < HOUR_W'(24)) && (out_ch.minute < MIN_W'(60))
      && (out_ch.second < SEC_W'(60)))
    else $error("result field out of range");

  // A held result keeps the pipe frozen behind it
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> ($stable(v6_r) && $stable(mon6_r)))
    else $error("pipeline moved during stall");

endmodule
